### src/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 digest block.
// No dependencies.
package sha_pkg;

  typedef enum logic [2:0] {
    S_IDLE, S_BYTES, S_PAD, S_LEN0, S_LEN1, S_START, S_WAIT, S_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    C_IDLE, C_LOAD, C_ROUND, C_FIN
  } core_state_e;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned RND_W  = $clog2(ROUNDS);

  typedef struct packed {
    logic        start;
    logic        hash_init;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
  } core_sts_t;

  localparam logic [3:0] LEN_HI_ADDR = 4'd14;
  localparam logic [3:0] LEN_LO_ADDR = 4'd15;
  localparam logic [7:0] PAD_BYTE    = 8'h80;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

### src/sha_in_if.sv
// Input channel of the SHA-256 digest block: message words.
// Depends on nothing.
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        message_end;
  modport source (output valid, data_word, valid_bytes, message_end, input ready);
  modport sink   (input valid, data_word, valid_bytes, message_end, output ready);
endinterface

### src/sha_out_if.sv
// Output channel of the SHA-256 digest block: digest words.
// Depends on nothing.
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### src/sha_core.sv
// Compression engine: block buffer memory, schedule window, round registers, hash.
// Depends on sha_pkg.
module sha_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha_pkg::core_ctl_t  ctl_i,
  output sha_pkg::core_sts_t  sts_o,
  input  logic [2:0]          dig_idx_i,
  output logic [31:0]         dig_o
);

  logic [31:0] blk_mem [16];
  logic [31:0] rdata_q;
  logic [3:0]  raddr;

  sha_pkg::core_state_e cst_q, cst_d;
  logic [sha_pkg::RND_W-1:0] rnd_q, rnd_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] w_new, t1, t2;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      blk_mem[ctl_i.wr_addr] <= ctl_i.wr_data;
    end
    rdata_q <= blk_mem[raddr];
  end

  assign raddr = (cst_q == sha_pkg::C_LOAD) ? 4'd0 : 4'(rnd_q + 1'b1);

  always_comb begin
    if (rnd_q[sha_pkg::RND_W-1:4] == '0) begin
      w_new = rdata_q;
    end else begin
      w_new = sha_pkg::ssig1(w_q[14]) + w_q[9] + sha_pkg::ssig0(w_q[1]) + w_q[0];
    end
    t1 = v_q[7] + sha_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + sha_pkg::K_TAB[rnd_q] + w_new;
    t2 = sha_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_comb begin
    cst_d = cst_q;
    rnd_d = rnd_q;
    case (cst_q)
      sha_pkg::C_IDLE: begin
        if (ctl_i.start) begin
          cst_d = sha_pkg::C_LOAD;
        end
      end
      sha_pkg::C_LOAD: begin
        cst_d = sha_pkg::C_ROUND;
        rnd_d = '0;
      end
      sha_pkg::C_ROUND: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == sha_pkg::RND_W'(sha_pkg::ROUNDS - 1)) begin
          cst_d = sha_pkg::C_FIN;
        end
      end
      sha_pkg::C_FIN: begin
        cst_d = sha_pkg::C_IDLE;
      end
      default: cst_d = sha_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q <= sha_pkg::C_IDLE;
      rnd_q <= '0;
    end else begin
      cst_q <= cst_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::init_hash(3'(i));
      end
    end else if (ctl_i.hash_init) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::init_hash(3'(i));
      end
    end else if (cst_q == sha_pkg::C_FIN) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cst_q == sha_pkg::C_LOAD) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (cst_q == sha_pkg::C_ROUND) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
    end
  end

  assign sts_o.busy = (cst_q != sha_pkg::C_IDLE);
  assign dig_o      = h_q[dig_idx_i];

endmodule

### src/sha256_message_digest.sv
// Top level of the SHA-256 digest block: byte packing, padding, length, output.
// Depends on sha_pkg, sha_in_if, sha_out_if and sha_core.
//
// channel | dir | payload                              | accepted when
// in_i    | in  | data_word, valid_bytes, message_end  | valid && ready
// out_o   | out | digest_word, word_index, last_word    | valid && ready
//
// One item at a time; valid bytes are packed one by one, and each 64-byte
// block is compressed by the single round unit (one round per cycle).
// A final item adds padding byte by byte, two length writes, one or
// two compressions, then eight output words, each of which waits on out ready.
// Reset loads the initial hash and clears the length; no clearing pass.
module sha256_message_digest (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha_in_if.sink     in_i,
  sha_out_if.source  out_o
);

  sha_pkg::top_state_e st_q, st_d, ret_q, ret_d;
  logic [31:0] word_q, word_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        end_q, end_d;
  logic        first_q, first_d;
  logic [5:0]  pos_q, pos_d;
  logic [60:0] len_q, len_d;
  logic [23:0] acc_q, acc_d;
  logic [2:0]  idx_q, idx_d;
  logic        ins;
  logic [7:0]  bval;

  sha_pkg::core_ctl_t ctl;
  sha_pkg::core_sts_t sts;

  always_comb begin
    st_d    = st_q;
    ret_d   = ret_q;
    word_d  = word_q;
    cnt_d   = cnt_q;
    end_d   = end_q;
    first_d = first_q;
    pos_d   = pos_q;
    len_d   = len_q;
    acc_d   = acc_q;
    idx_d   = idx_q;
    ins     = 1'b0;
    bval    = word_q[31:24];
    ctl     = '0;
    case (st_q)
      sha_pkg::S_IDLE: begin
        if (in_i.valid) begin
          word_d = in_i.data_word;
          cnt_d  = (in_i.valid_bytes > 3'd4) ? 3'd4 : in_i.valid_bytes;
          end_d  = in_i.message_end;
          st_d   = sha_pkg::S_BYTES;
        end
      end
      sha_pkg::S_BYTES: begin
        if (cnt_q == 3'd0) begin
          first_d = 1'b1;
          st_d    = end_q ? sha_pkg::S_PAD : sha_pkg::S_IDLE;
        end else begin
          ins    = 1'b1;
          word_d = {word_q[23:0], 8'd0};
          cnt_d  = cnt_q - 3'd1;
          len_d  = len_q + 61'd1;
          if (pos_q == 6'd63) begin
            st_d  = sha_pkg::S_START;
            ret_d = sha_pkg::S_BYTES;
          end
        end
      end
      sha_pkg::S_PAD: begin
        ins     = 1'b1;
        bval    = first_q ? sha_pkg::PAD_BYTE : 8'd0;
        first_d = 1'b0;
        if (pos_q == 6'd63) begin
          st_d  = sha_pkg::S_START;
          ret_d = sha_pkg::S_PAD;
        end else if (pos_q == 6'd55) begin
          st_d = sha_pkg::S_LEN0;
        end
      end
      sha_pkg::S_LEN0: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_addr = sha_pkg::LEN_HI_ADDR;
        ctl.wr_data = len_q[60:29];
        st_d        = sha_pkg::S_LEN1;
      end
      sha_pkg::S_LEN1: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_addr = sha_pkg::LEN_LO_ADDR;
        ctl.wr_data = {len_q[28:0], 3'd0};
        st_d        = sha_pkg::S_START;
        ret_d       = sha_pkg::S_OUT;
      end
      sha_pkg::S_START: begin
        ctl.start = 1'b1;
        st_d      = sha_pkg::S_WAIT;
      end
      sha_pkg::S_WAIT: begin
        if (!sts.busy) begin
          st_d = ret_q;
        end
      end
      sha_pkg::S_OUT: begin
        if (out_o.ready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            ctl.hash_init = 1'b1;
            len_d         = '0;
            pos_d         = '0;
            st_d          = sha_pkg::S_IDLE;
          end
        end
      end
      default: st_d = sha_pkg::S_IDLE;
    endcase
    if (ins) begin
      pos_d = pos_q + 6'd1;
      acc_d = {acc_q[15:0], bval};
      if (pos_q[1:0] == 2'd3) begin
        ctl.wr_en   = 1'b1;
        ctl.wr_addr = pos_q[5:2];
        ctl.wr_data = {acc_q, bval};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= sha_pkg::S_IDLE;
      ret_q   <= sha_pkg::S_IDLE;
      cnt_q   <= '0;
      end_q   <= 1'b0;
      first_q <= 1'b0;
      pos_q   <= '0;
      len_q   <= '0;
      idx_q   <= '0;
    end else begin
      st_q    <= st_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      end_q   <= end_d;
      first_q <= first_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    acc_q  <= acc_d;
  end

  sha_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .dig_idx_i (idx_q),
    .dig_o     (out_o.digest_word)
  );

  assign in_i.ready        = (st_q == sha_pkg::S_IDLE);
  assign out_o.valid       = (st_q == sha_pkg::S_OUT);
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'd7);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.start |-> !sts.busy) else $error("compression started while busy");

  a_wait_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == sha_pkg::S_START) |=> sts.busy) else $error("core did not start");

  a_out_core_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!sts.busy && pos_q == 6'd56)) else $error("digest shown too early");

  a_len_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == sha_pkg::S_LEN0) |-> (pos_q == 6'd56)) else $error("length written off place");

endmodule

### test/sha_digest_sb.sv
`timescale 1ns / 100ps
// Scoreboard for the SHA-256 digest block: streaming SHA-256 predictor and
// a queue of expected digest words. Depends on nothing.
class sha_digest_sb;
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] KC [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0] hash_q [8];
  logic [7:0]  block_q [64];
  logic [60:0] msg_len;
  digest_t     digest_q [$];
  int          errors;
  int          digests;

  function new();
    hash_q  = IV;
    msg_len = '0;
    errors  = 0;
    digests = 0;
    foreach (block_q[i]) block_q[i] = '0;
  endfunction

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w[t] = {block_q[4*t], block_q[4*t+1], block_q[4*t+2], block_q[4*t+3]};
      end else begin
        w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
               (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      end
    end
    v = hash_q;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + KC[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += v[i];
  endfunction

  function void note_input(logic [31:0] data, logic [2:0] nbytes, logic msg_end);
    int cnt;
    int pos;
    logic [63:0] bits;
    digest_t d;
    cnt = (nbytes > 4) ? 4 : nbytes;
    for (int k = 0; k < cnt; k++) begin
      pos = msg_len[5:0];
      block_q[pos] = data[31-8*k -: 8];
      msg_len++;
      if (pos == 63) compress_block();
    end
    if (!msg_end) return;
    pos = msg_len[5:0];
    block_q[pos] = 8'h80;
    for (int k = pos + 1; k < 64; k++) block_q[k] = '0;
    if (pos > 55) begin
      compress_block();
      foreach (block_q[i]) block_q[i] = '0;
    end
    bits = {msg_len, 3'b000};
    for (int k = 0; k < 8; k++) block_q[56+k] = bits[63-8*k -: 8];
    compress_block();
    for (int k = 0; k < 8; k++) begin
      d.word  = hash_q[k];
      d.index = 3'(k);
      d.last  = (k == 7);
      digest_q.push_back(d);
    end
    hash_q  = IV;
    msg_len = '0;
    digests++;
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  task check_digest(logic [31:0] word, logic [2:0] index, logic last);
    digest_t d;
    if (digest_q.size() == 0) begin
      report("unexpected digest word", word, 32'd0);
      return;
    end
    d = digest_q.pop_front();
    if (word !== d.word) report("digest_word", word, d.word);
    if (index !== d.index) report("word_index", 32'(index), 32'(d.index));
    if (last !== d.last) report("last_word", 32'(last), 32'(d.last));
  endtask
endclass

### test/tb.sv
`timescale 1ns / 100ps
// Testbench top for sha256_message_digest: drives message words, checks the digest
// words against the scoreboard. Needs the DUT, sha_in_if, sha_out_if, sha_digest_sb.
module tb;
  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   stall_cnt = 0;
  int   n_items = 0;
  bit   timed_out = 1'b0;
  sha_digest_sb sb = new();

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_message_digest u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid       = 1'b0;
    in_if.data_word   = '0;
    in_if.valid_bytes = '0;
    in_if.message_end = 1'b0;
    out_if.ready      = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_digest(out_if.digest_word, out_if.word_index, out_if.last_word);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (stall_cnt >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("Watchdog expired after %0d idle cycles", WATCHDOG);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] data, logic [2:0] nbytes, logic msg_end);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.data_word   <= data;
    in_if.valid_bytes <= nbytes;
    in_if.message_end <= msg_end;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(data, nbytes, msg_end);
    n_items++;
  endtask

  task automatic send_message(int words, logic [2:0] tail);
    for (int i = 0; i < words; i++) send_word($urandom(), 3'd4, 1'b0);
    send_word($urandom(), tail, 1'b1);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.digest_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, "abc", field extremes, block-boundary padding
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b0);
    send_word(32'h00000000, 3'd5, 1'b0);
    send_word(32'hdeadbeef, 3'd1, 1'b0);
    send_word(32'h12345678, 3'd2, 1'b0);
    send_word(32'hffffffff, 3'd6, 1'b1);
    send_message(13, 3'd3);
    drain();
    send_message(14, 3'd0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 24 : (ph == 1) ? 74 : 0;
      recv_idle = (ph == 0) ? 74 : (ph == 1) ? 24 : 0;
      for (int m = 0; m < 5; m++) begin
        if ($urandom_range(9) == 0) begin
          for (int j = 0; j < $urandom_range(4, 1); j++)
            send_word($urandom(), 3'($urandom_range(7)), 1'b0);
          send_word($urandom(), 3'($urandom_range(7)), 1'b1);
        end else begin
          send_message($urandom_range(18), 3'($urandom_range(4)));
        end
      end
      drain();
    end
    recv_idle = 0;
    repeat (100) @(posedge clk_i);
    $display("Sent %0d items forming %0d messages, lengths 0 to about 76 bytes,",
             n_items, sb.digests);
    $display("with input and output stalls and mid-message short words.");
    if (sb.errors == 0 && sb.digest_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### sha256_message_digest.f
src/sha_pkg.sv
src/sha_in_if.sv
src/sha_out_if.sv
src/sha_core.sv
src/sha256_message_digest.sv
test/sha_digest_sb.sv
test/tb.sv
